// ===== rtl/core/pcx_pkg.sv =====
// Package: shared types, codes and constants of the PCX run-length pixel decoder.
package pcx_pkg;

    localparam int MaxWidthDefault = 4096;
    localparam int PaletteEntriesDefault = 256;

    localparam logic [1:0] FMT_MONO   = 2'd0;
    localparam logic [1:0] FMT_NIBBLE = 2'd1;
    localparam logic [1:0] FMT_PAL8   = 2'd2;
    localparam logic [1:0] FMT_RGB24  = 2'd3;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_LBYTES = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RUN_CUT   = 2'd1;
    localparam logic [1:0] STATUS_EARLY_END = 2'd2;

    localparam logic [1:0] RUN_MARK = 2'b11;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_value;
        logic [7:0]  pal_index;
        logic [23:0] pal_rgb;
        logic        last_byte;
    } pcx_in_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [15:0] pixel_y;
        logic [3:0]  pixel_count;
        logic [23:0] first_rgb;
        logic [23:0] second_rgb;
        logic [7:0]  mono_bits;
        logic [1:0]  status;
        logic        run_last;
    } pcx_out_t;

    // Position of the decoder inside the image.
    typedef struct packed {
        logic [13:0] column;
        logic [1:0]  plane;
        logic [15:0] pad_left;
        logic [15:0] row;
        logic        image_done;
    } pcx_pos_t;

    // Configuration seen by the step unit.
    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [12:0] image_width;
        logic [15:0] image_height;
        logic [15:0] line_bytes;
    } pcx_cfg_t;

    // Outcome of one decoded byte.
    typedef struct packed {
        pcx_pos_t   pos;
        logic       emit;
        logic [3:0] count;
        logic [7:0] mono_bits;
        logic       red_we;
        logic       green_we;
    } pcx_step_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_STEP,
        ST_FINISH
    } pcx_state_t;

endpackage

// ===== rtl/core/pcx_rle_pixel_decoder.sv =====
// Top level: PCX run-length pixel decoder with sequencer, palette and line store.
// Flow: a literal passes the states RD_A, RD_B and STEP into the hold register, and FINISH
// moves it to the result register; inside a run each pixel beat waits in the hold register
// until the next pixel's step or FINISH. Each decoded byte uses the shared step unit after two
// palette reads through one RAM port; the input is stalled while the sequencer is busy with a
// beat, including a status beat after a pixel and any output stalls. Palette writes and run
// headers that are not the last byte are taken without leaving the idle state.
// Reset clears all stream state and returns the config registers to their defaults;
// palette and line store are not cleared.
module pcx_rle_pixel_decoder #(
    parameter int MAX_WIDTH       = pcx_pkg::MaxWidthDefault,
    parameter int PALETTE_ENTRIES = pcx_pkg::PaletteEntriesDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pcx_pkg::pcx_in_t  item,
    output logic              pix_valid,
    input  logic              pix_stall,
    output pcx_pkg::pcx_out_t pix,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import pcx_pkg::*;

    localparam int PAW = $clog2(PALETTE_ENTRIES);
    localparam int LAW = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic [1:0]  fmt_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [15:0] lbytes_reg;

    // Sequencer and stream state.
    pcx_state_t  state_reg, state_next;
    pcx_pos_t    pos_reg, pos_next;
    logic [5:0]  run_left_reg, run_left_next;
    logic [7:0]  run_value_reg, run_value_next;
    logic        run_pending_reg, run_pending_next;
    logic        last_reg, last_next;
    logic        hdr_last_reg, hdr_last_next;
    logic [23:0] first_reg, first_next;
    logic [15:0] rg_reg, rg_next;

    // Result register and the pixel beat held until the next result is known.
    logic        pix_valid_reg, pix_valid_next;
    pcx_out_t    pix_reg, pix_next;
    logic        hold_valid_reg, hold_valid_next;
    pcx_out_t    hold_reg, hold_next;

    pcx_cfg_t    cfg;
    pcx_step_t   step;
    logic        accept;
    logic        out_free;
    logic        step_go;
    logic        finish_done;
    logic [1:0]  fin_code;

    logic [7:0]     pal_addr8;
    logic [23:0]    pal_rdata;
    logic           pal_we;
    logic [7:0]     red_rdata;
    logic [7:0]     green_rdata;
    logic [31:0]    col32;
    logic           col_in_range;
    logic           line_we_ok;
    logic           pal_first_ok;

    assign cfg_ready  = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !pix_valid_reg || !pix_stall;
    assign pix_valid  = pix_valid_reg;
    assign pix        = pix_reg;

    // A step that emits pushes any held beat out first, so it then needs a free result slot.
    assign step_go     = !step.emit || !hold_valid_reg || out_free;
    // Finish once the held beat and any status beat have both left.
    assign finish_done = hold_valid_reg ? (out_free && fin_code == STATUS_OK)
                                        : (fin_code == STATUS_OK || out_free);

    assign cfg.pixel_format = fmt_reg;
    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;
    assign cfg.line_bytes   = lbytes_reg;

    assign col32        = 32'(pos_reg.column);
    assign col_in_range = col32 < MAX_WIDTH;
    assign pal_we       = accept && item.mode && ({1'b0, item.pal_index} < 9'(PALETTE_ENTRIES));
    assign pal_first_ok = (fmt_reg == FMT_NIBBLE) ||
                          ({1'b0, run_value_reg} < 9'(PALETTE_ENTRIES));

    // First read fetches the high nibble (or whole byte), later cycles the low nibble.
    always_comb
    begin
        if (state_reg == ST_RD_A && fmt_reg == FMT_NIBBLE)
        begin
            pal_addr8 = {4'd0, run_value_reg[7:4]};
        end
        else if (state_reg == ST_RD_A)
        begin
            pal_addr8 = run_value_reg;
        end
        else
        begin
            pal_addr8 = {4'd0, run_value_reg[3:0]};
        end
    end

    pcx_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (item.pal_index[PAW-1:0]),
        .wr_data (item.pal_rgb),
        .rd_addr (pal_addr8[PAW-1:0]),
        .rd_data (pal_rdata)
    );

    // Line store split by plane: red and green bytes of each column.
    assign line_we_ok = (state_reg == ST_STEP) && col_in_range;

    pcx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_red_line (
        .clk     (clk),
        .wr_en   (line_we_ok && step.red_we),
        .wr_addr (col32[LAW-1:0]),
        .wr_data (run_value_reg),
        .rd_addr (col32[LAW-1:0]),
        .rd_data (red_rdata)
    );

    pcx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_green_line (
        .clk     (clk),
        .wr_en   (line_we_ok && step.green_we),
        .wr_addr (col32[LAW-1:0]),
        .wr_data (run_value_reg),
        .rd_addr (col32[LAW-1:0]),
        .rd_data (green_rdata)
    );

    pcx_step u_step (
        .cfg   (cfg),
        .pos   (pos_reg),
        .value (run_value_reg),
        .res   (step)
    );

    // Status owed at the end of the beat: cut run header, or data ended early.
    always_comb
    begin
        if (hdr_last_reg)
        begin
            fin_code = STATUS_RUN_CUT;
        end
        else if (last_reg && !pos_reg.image_done)
        begin
            fin_code = STATUS_EARLY_END;
        end
        else
        begin
            fin_code = STATUS_OK;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !item.mode && !pos_reg.image_done)
                begin
                    if (run_pending_reg)
                    begin
                        state_next = (run_left_reg != 6'd0) ? ST_RD_A : ST_FINISH;
                    end
                    else if (item.data_value[7:6] == RUN_MARK)
                    begin
                        state_next = item.last_byte ? ST_FINISH : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD_A;
                    end
                end
            end
            ST_RD_A:
            begin
                state_next = ST_RD_B;
            end
            ST_RD_B:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (step_go)
                begin
                    state_next = (run_left_reg == 6'd1) ? ST_FINISH : ST_RD_A;
                end
            end
            ST_FINISH:
            begin
                if (finish_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register.
    always_comb
    begin
        pos_next         = pos_reg;
        run_left_next    = run_left_reg;
        run_value_next   = run_value_reg;
        run_pending_next = run_pending_reg;
        last_next        = last_reg;
        hdr_last_next    = hdr_last_reg;
        first_next       = first_reg;
        rg_next          = rg_reg;
        pix_next         = pix_reg;
        pix_valid_next   = pix_valid_reg && pix_stall;
        hold_next        = hold_reg;
        hold_valid_next  = hold_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !item.mode)
                begin
                    last_next     = item.last_byte;
                    hdr_last_next = 1'b0;
                    if (pos_reg.image_done)
                    begin
                        // bytes past the image: drop, restart on the final one
                        if (item.last_byte)
                        begin
                            pos_next         = '0;
                            run_left_next    = 6'd0;
                            run_value_next   = 8'd0;
                            run_pending_next = 1'b0;
                        end
                    end
                    else if (run_pending_reg)
                    begin
                        run_pending_next = 1'b0;
                        run_value_next   = item.data_value;
                    end
                    else if (item.data_value[7:6] == RUN_MARK)
                    begin
                        if (item.last_byte)
                        begin
                            hdr_last_next = 1'b1;
                        end
                        else
                        begin
                            run_left_next    = item.data_value[5:0];
                            run_pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        run_value_next = item.data_value;
                        run_left_next  = 6'd1;
                    end
                end
            end
            ST_RD_A:
            begin
            end
            ST_RD_B:
            begin
                first_next = pal_first_ok ? pal_rdata : 24'd0;
                rg_next    = col_in_range ? {red_rdata, green_rdata} : 16'd0;
            end
            ST_STEP:
            begin
                if (step_go)
                begin
                    pos_next      = step.pos;
                    run_left_next = run_left_reg - 6'd1;
                    if (step.emit)
                    begin
                        // a later pixel follows, so the held one is not the last of the beat
                        if (hold_valid_reg)
                        begin
                            pix_valid_next = 1'b1;
                            pix_next       = hold_reg;
                        end
                        hold_valid_next       = 1'b1;
                        hold_next             = '0;
                        hold_next.pixel_x     = pos_reg.column[11:0];
                        hold_next.pixel_y     = pos_reg.row;
                        hold_next.pixel_count = step.count;
                        hold_next.mono_bits   = step.mono_bits;
                        hold_next.status      = STATUS_OK;
                        hold_next.run_last    = 1'b0;
                        unique case (fmt_reg)
                            FMT_MONO:
                            begin
                                hold_next.first_rgb = 24'd0;
                            end
                            FMT_NIBBLE:
                            begin
                                hold_next.first_rgb  = first_reg;
                                hold_next.second_rgb = (step.count == 4'd2) ? pal_rdata : 24'd0;
                            end
                            FMT_PAL8:
                            begin
                                hold_next.first_rgb = first_reg;
                            end
                            default:
                            begin
                                hold_next.first_rgb = {rg_reg, run_value_reg};
                            end
                        endcase
                    end
                end
            end
            ST_FINISH:
            begin
                if (hold_valid_reg)
                begin
                    // release the held pixel; it closes the beat unless a status follows
                    if (out_free)
                    begin
                        pix_valid_next    = 1'b1;
                        pix_next          = hold_reg;
                        pix_next.run_last = (fin_code == STATUS_OK);
                        hold_valid_next   = 1'b0;
                    end
                end
                else if (fin_code != STATUS_OK && out_free)
                begin
                    pix_valid_next    = 1'b1;
                    pix_next          = '0;
                    pix_next.status   = fin_code;
                    pix_next.run_last = 1'b1;
                end
                if (finish_done)
                begin
                    if (last_reg)
                    begin
                        pos_next         = '0;
                        run_left_next    = 6'd0;
                        run_value_next   = 8'd0;
                        run_pending_next = 1'b0;
                    end
                    hdr_last_next = 1'b0;
                    last_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg         <= FMT_PAL8;
            width_reg       <= 13'd1;
            height_reg      <= 16'd1;
            lbytes_reg      <= 16'd1;
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            run_left_reg    <= 6'd0;
            run_value_reg   <= 8'd0;
            run_pending_reg <= 1'b0;
            last_reg        <= 1'b0;
            hdr_last_reg    <= 1'b0;
            pix_valid_reg   <= 1'b0;
            hold_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FORMAT: fmt_reg    <= cfg_data[1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[12:0];
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_LBYTES: lbytes_reg <= cfg_data;
                    default:    lbytes_reg <= lbytes_reg;
                endcase
            end
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            run_left_reg    <= run_left_next;
            run_value_reg   <= run_value_next;
            run_pending_reg <= run_pending_next;
            last_reg        <= last_next;
            hdr_last_reg    <= hdr_last_next;
            pix_valid_reg   <= pix_valid_next;
            hold_valid_reg  <= hold_valid_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        rg_reg    <= rg_next;
        pix_reg   <= pix_next;
        hold_reg  <= hold_next;
    end

`ifndef NO_ASSERTIONS
    // A status beat carries no pixels and always closes its input beat.
    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && pix_reg.status != STATUS_OK) |->
            (pix_reg.pixel_count == 4'd0 && pix_reg.run_last))
        else $error("status beat with pixels or without run_last");

    // A waiting run header only exists between input beats.
    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        run_pending_reg |-> (state_reg == ST_IDLE))
        else $error("run header pending while sequencer busy");

    // The step loop never runs with an exhausted repeat count.
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_A || state_reg == ST_RD_B || state_reg == ST_STEP) |->
            (run_left_reg != 6'd0))
        else $error("step loop with zero repeat count");

    // A pixel beat never carries more than one byte of mono pixels.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg |-> (pix_reg.pixel_count <= 4'd8))
        else $error("pixel count out of range");

    // No pixel is left behind once the sequencer is idle.
    a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held pixel beat while idle");
`endif

endmodule

// ===== rtl/core/pcx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/core/pcx_step.sv =====
// Step unit: advances the image position by one decoded byte.
module pcx_step (
    input  pcx_pkg::pcx_cfg_t  cfg,
    input  pcx_pkg::pcx_pos_t  pos,
    input  logic [7:0]         value,
    output pcx_pkg::pcx_step_t res
);
    import pcx_pkg::*;

    logic [13:0] w;
    logic [16:0] h;
    logic [13:0] rem;
    logic [3:0]  cnt;
    logic [13:0] col_n;
    logic [13:0] db;
    logic        final_plane;
    logic [16:0] row_p1;

    always_comb
    begin
        w      = (cfg.image_width == 13'd0) ? 14'd1 : {1'b0, cfg.image_width};
        h      = (cfg.image_height == 16'd0) ? 17'd1 : {1'b0, cfg.image_height};
        rem    = (w > pos.column) ? (w - pos.column) : 14'd0;
        row_p1 = {1'b0, pos.row} + 17'd1;
        final_plane = (cfg.pixel_format != FMT_RGB24) || (pos.plane >= 2'd2);
        unique case (cfg.pixel_format)
            FMT_MONO:   db = 14'((w + 14'd7) >> 3);
            FMT_NIBBLE: db = 14'((w + 14'd1) >> 1);
            default:    db = w;
        endcase
        if (rem == 14'd0)
        begin
            cnt = 4'd0;
        end
        else
        begin
            unique case (cfg.pixel_format)
                FMT_MONO:   cnt = (rem < 14'd8) ? rem[3:0] : 4'd8;
                FMT_NIBBLE: cnt = (rem < 14'd2) ? rem[3:0] : 4'd2;
                default:    cnt = 4'd1;
            endcase
        end
        col_n = pos.column + 14'(cnt);

        res           = '0;
        res.pos       = pos;
        res.count     = cnt;
        res.mono_bits = (cfg.pixel_format == FMT_MONO) ? (value & ~(8'hff >> cnt)) : 8'd0;

        if (!pos.image_done)
        begin
            if (pos.pad_left != 16'd0)
            begin
                // skip padding; the last pad byte closes the plane
                res.pos.pad_left = pos.pad_left - 16'd1;
                if (pos.pad_left == 16'd1)
                begin
                    res.pos.column = 14'd0;
                    if (cfg.pixel_format == FMT_RGB24 && pos.plane < 2'd2)
                    begin
                        res.pos.plane = pos.plane + 2'd1;
                    end
                    else
                    begin
                        res.pos.plane = 2'd0;
                        res.pos.row   = pos.row + 16'd1;
                    end
                end
            end
            else
            begin
                if (rem != 14'd0)
                begin
                    if (cfg.pixel_format == FMT_RGB24 && pos.plane == 2'd0)
                    begin
                        res.red_we = 1'b1;
                    end
                    else if (cfg.pixel_format == FMT_RGB24 && pos.plane == 2'd1)
                    begin
                        res.green_we = 1'b1;
                    end
                    else
                    begin
                        res.emit = 1'b1;
                    end
                end
                res.pos.column = col_n;
                if (col_n >= w)
                begin
                    if (final_plane && row_p1 >= h)
                    begin
                        res.pos.image_done = 1'b1;
                    end
                    else if ({1'b0, cfg.line_bytes} > {3'd0, db})
                    begin
                        res.pos.pad_left = 16'({1'b0, cfg.line_bytes} - {3'd0, db});
                    end
                    else
                    begin
                        res.pos.column = 14'd0;
                        if (cfg.pixel_format == FMT_RGB24 && pos.plane < 2'd2)
                        begin
                            res.pos.plane = pos.plane + 2'd1;
                        end
                        else
                        begin
                            res.pos.plane = 2'd0;
                            res.pos.row   = pos.row + 16'd1;
                        end
                    end
                end
            end
        end
    end
endmodule
